// ===== src/kvi_pkg.sv =====
// Shared constants and types for the keyframe vertex interpolator.
package kvi_pkg;

    localparam int COORD_FRAC_BITS = 16;

    // compressed coordinate, blend and texel fields
    localparam int CC_W  = 8;
    localparam int BL_W  = 9;
    localparam int TC_W  = 12;
    localparam int SZ_W  = 13;
    localparam int POS_W = 32;
    localparam int TEX_W = 17;

    localparam logic [BL_W-1:0]  BLEND_ONE = BL_W'(256);
    localparam logic [TEX_W-1:0] TEX_MAX   = {TEX_W{1'b1}};

    // position datapath widths
    localparam int P_W    = 2 * CC_W;            // blended Q8.8, never negative
    localparam int PROD_W = POS_W + P_W + 1;
    localparam int RND_W  = PROD_W + 1;
    localparam int Q_W    = RND_W - CC_W;
    localparam int SUM_W  = Q_W + 1;

    // texture divider: h = 2c+1 (+ skin width), quotient has one extra bit for saturation
    localparam int H_W    = SZ_W + 1;
    localparam int D_W    = SZ_W + 1;
    localparam int QB     = TEX_W + 1;
    localparam int QI_W   = $clog2(QB);
    localparam int NUM_W  = H_W + COORD_FRAC_BITS + 1;
    localparam int REM_W  = (NUM_W > D_W + TEX_W) ? NUM_W : D_W + TEX_W;
    localparam int DIV_PER = 3;
    localparam int DIV_ST  = (QB + DIV_PER - 1) / DIV_PER;

    // one prep stage, then the divider stages; the last one is the output register
    localparam int NST = DIV_ST + 1;

    // register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSLATE_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSLATE_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSLATE_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SKIN_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SKIN_HEIGHT = 3'd7;

    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 136;
    localparam int S_USER_W = 2;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QB-1:0]    quo;
    } t_div;

endpackage

// ===== src/keyframe_vertex_interpolator.sv =====
// Keyframe vertex interpolator: 7-stage pipeline, blended position and normalized texcoords.
// Throughput: one vertex per cycle while the output is not stalled; the depth is set by the texture divider,
// a restoring divider resolving 3 quotient bits per stage over 6 stages.
// Stages stall individually, so bubbles are squeezed out behind a blocked output.
// Reset (synchronous, active low) empties the pipeline and loads scale 1.0,
// translate 0 and a 256 by 256 skin.
module keyframe_vertex_interpolator
    import kvi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // cfg write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    // input vertex stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // cur_x, cur_y, cur_z, nxt_x, nxt_y, nxt_z, blend, tex_s, tex_t, zero pad
    input  logic [S_DATA_W-1:0]  i_s_tdata,
    // on_seam, faces_front
    input  logic [S_USER_W-1:0]  i_s_tuser,
    input  logic                 i_s_tlast,
    // output vertex stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v, zero pad
    output logic [M_DATA_W-1:0]  o_m_tdata,
    output logic                 o_m_tlast
);

    // configuration
    logic signed [POS_W-1:0] r_scale [3];
    logic signed [POS_W-1:0] r_trn   [3];
    logic [SZ_W-1:0]         r_sw;
    logic [SZ_W-1:0]         r_sh;

    // pipeline control
    logic [NST-1:0] r_vld;
    logic [NST:0]   stg_rdy;

    // position payload
    logic [P_W-1:0]           r_p    [3];
    logic signed [PROD_W-1:0] r_prod [3];
    logic signed [Q_W-1:0]    r_q    [3];
    logic [POS_W-1:0]         r_pos  [3:NST-1][3];

    // texture payload
    t_div           r_ds [NST];
    t_div           r_dt [NST];
    logic [D_W-1:0] r_den_s [NST-1];
    logic [D_W-1:0] r_den_t [NST-1];
    logic           r_last [NST];

    // stage 0 inputs
    logic [CC_W-1:0]       in_cur [3];
    logic [CC_W-1:0]       in_nxt [3];
    logic [BL_W-1:0]       in_blend;
    logic [TC_W-1:0]       in_s;
    logic [TC_W-1:0]       in_t;
    logic [BL_W-1:0]       blend_c;
    logic signed [BL_W-1:0] diff [3];
    logic signed [18:0]    fd   [3];
    logic signed [18:0]    psum [3];
    logic [P_W-1:0]        n_p  [3];
    logic [H_W-1:0]        h_s;
    logic [H_W-1:0]        h_t;
    t_div                  n_ds0;
    t_div                  n_dt0;

    // later stage next values
    logic signed [PROD_W-1:0] n_prod [3];
    logic signed [RND_W-1:0]  rnd    [3];
    logic signed [Q_W-1:0]    n_q    [3];
    logic signed [SUM_W-1:0]  psat   [3];
    logic [POS_W-1:0]         n_pos  [3];
    t_div                     n_ds   [1:NST-1];
    t_div                     n_dt   [1:NST-1];
    logic [TEX_W-1:0]         tex_u;
    logic [TEX_W-1:0]         tex_v;

    function automatic t_div div_steps(t_div cur, logic [D_W-1:0] d, int base);
        t_div             acc;
        logic [REM_W-1:0] sub;
        int               i;
        acc = cur;
        for (int j = 0; j < DIV_PER; j++) begin
            i = QB - 1 - base - j;
            if (i >= 0) begin
                sub = REM_W'(d) << i;
                if (acc.rem >= sub) begin
                    acc.rem = acc.rem - sub;
                    acc.quo[i[QI_W-1:0]] = 1'b1;
                end
            end
        end
        return acc;
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_scale[k] <= 32'sd65536;
                r_trn[k]   <= '0;
            end
            r_sw <= SZ_W'(256);
            r_sh <= SZ_W'(256);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SCALE_X:     r_scale[0] <= i_cfg_data;
                REG_SCALE_Y:     r_scale[1] <= i_cfg_data;
                REG_SCALE_Z:     r_scale[2] <= i_cfg_data;
                REG_TRANSLATE_X: r_trn[0]   <= i_cfg_data;
                REG_TRANSLATE_Y: r_trn[1]   <= i_cfg_data;
                REG_TRANSLATE_Z: r_trn[2]   <= i_cfg_data;
                REG_SKIN_WIDTH:  r_sw       <= i_cfg_data[SZ_W-1:0];
                REG_SKIN_HEIGHT: r_sh       <= i_cfg_data[SZ_W-1:0];
                default: ;
            endcase
        end
    end

    // a stage takes a beat when it is empty or its successor moves on
    always_comb begin
        stg_rdy[NST] = i_m_tready;
        for (int k = NST - 1; k >= 0; k--) begin
            stg_rdy[k] = !r_vld[k] || stg_rdy[k+1];
        end
    end

    assign o_s_tready = stg_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_rdy[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (stg_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 0: blend and divider operands
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            in_cur[k] = i_s_tdata[k*CC_W +: CC_W];
            in_nxt[k] = i_s_tdata[(k+3)*CC_W +: CC_W];
        end
        in_blend = i_s_tdata[6*CC_W +: BL_W];
        in_s     = i_s_tdata[6*CC_W+BL_W +: TC_W];
        in_t     = i_s_tdata[6*CC_W+BL_W+TC_W +: TC_W];
        blend_c  = (in_blend > BLEND_ONE) ? BLEND_ONE : in_blend;
        for (int k = 0; k < 3; k++) begin
            diff[k] = $signed({1'b0, in_nxt[k]}) - $signed({1'b0, in_cur[k]});
            fd[k]   = $signed({1'b0, blend_c}) * diff[k];
            psum[k] = $signed({3'b0, in_cur[k], 8'b0}) + fd[k];
            n_p[k]  = psum[k][P_W-1:0];
        end
        // back-facing seam vertex picks the other half of the skin
        h_s = {1'b0, in_s, 1'b1} + ((i_s_tuser[0] && !i_s_tuser[1]) ? H_W'(r_sw) : '0);
        h_t = {1'b0, in_t, 1'b1};
        n_ds0.rem = (REM_W'(h_s) << COORD_FRAC_BITS) + REM_W'(r_sw);
        n_ds0.quo = '0;
        n_dt0.rem = (REM_W'(h_t) << COORD_FRAC_BITS) + REM_W'(r_sh);
        n_dt0.quo = '0;
    end

    // position stages 1..3 and divider stages 1..NST-1
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_prod[k] = r_scale[k] * $signed({1'b0, r_p[k]});
            rnd[k]    = RND_W'(r_prod[k]) + RND_W'(128);
            n_q[k]    = rnd[k][RND_W-1:CC_W];
            psat[k]   = SUM_W'(r_q[k]) + SUM_W'(r_trn[k]);
            if (psat[k][SUM_W-1:POS_W-1] != {(SUM_W-POS_W+1){psat[k][POS_W-1]}}) begin
                n_pos[k] = psat[k][SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}}
                                            : {1'b0, {(POS_W-1){1'b1}}};
            end else begin
                n_pos[k] = psat[k][POS_W-1:0];
            end
        end
        for (int s = 1; s < NST; s++) begin
            n_ds[s] = div_steps(r_ds[s-1], r_den_s[s-1], (s - 1) * DIV_PER);
            n_dt[s] = div_steps(r_dt[s-1], r_den_t[s-1], (s - 1) * DIV_PER);
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[0]) begin
            r_p        <= n_p;
            r_ds[0]    <= n_ds0;
            r_dt[0]    <= n_dt0;
            r_den_s[0] <= {r_sw, 1'b0};
            r_den_t[0] <= {r_sh, 1'b0};
            r_last[0]  <= i_s_tlast;
        end
        if (stg_rdy[1]) r_prod <= n_prod;
        if (stg_rdy[2]) r_q    <= n_q;
        if (stg_rdy[3]) r_pos[3] <= n_pos;
        for (int s = 4; s < NST; s++) begin
            if (stg_rdy[s]) r_pos[s] <= r_pos[s-1];
        end
        for (int s = 1; s < NST; s++) begin
            if (stg_rdy[s]) begin
                r_ds[s]   <= n_ds[s];
                r_dt[s]   <= n_dt[s];
                r_last[s] <= r_last[s-1];
            end
        end
        for (int s = 1; s < NST - 1; s++) begin
            if (stg_rdy[s]) begin
                r_den_s[s] <= r_den_s[s-1];
                r_den_t[s] <= r_den_t[s-1];
            end
        end
    end

    // top quotient bit set means the result is past the Q1.16 range (or the size is zero)
    assign tex_u = r_ds[NST-1].quo[QB-1] ? TEX_MAX : r_ds[NST-1].quo[TEX_W-1:0];
    assign tex_v = r_dt[NST-1].quo[QB-1] ? TEX_MAX : r_dt[NST-1].quo[TEX_W-1:0];

    assign o_m_tvalid = r_vld[NST-1];
    assign o_m_tlast  = r_last[NST-1];
    assign o_m_tdata  = {{(M_DATA_W - 3*POS_W - 2*TEX_W){1'b0}}, tex_v, tex_u,
                         r_pos[NST-1][2], r_pos[NST-1][1], r_pos[NST-1][0]};

endmodule

// ===== src/kvi_checker.sv =====
// Port-level checks for the keyframe vertex interpolator, bound to the top level.
module kvi_checker
    import kvi_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_DATA_W-1:0]  o_m_tdata,
    input logic                 o_m_tlast
);

    // a free output means every stage can move, so the input side must be open
    a_ready_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tready |-> o_s_tready)
        else $error("input not ready while output is free");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output beat right after reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output beat dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled output beat changed");

endmodule

bind keyframe_vertex_interpolator kvi_checker u_kvi_checker (.*);

// ===== sim/tb_keyframe_vertex_interpolator.sv =====
// Stream testbench for the keyframe vertex interpolator with a built-in position/texcoord predictor.
module tb_keyframe_vertex_interpolator;
    import kvi_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 12;
    localparam longint POS_HI   = 64'sd2147483647;
    localparam longint POS_LO   = -64'sd2147483648;

    typedef struct packed {
        logic [2:0][CC_W-1:0] cur;
        logic [2:0][CC_W-1:0] nxt;
        logic [BL_W-1:0]      blend;
        logic [TC_W-1:0]      tex_s;
        logic [TC_W-1:0]      tex_t;
        logic                 on_seam;
        logic                 faces_front;
        logic                 last_in;
    } t_vertex;

    typedef struct packed {
        logic [2:0][POS_W-1:0] pos;
        logic [TEX_W-1:0]      tex_u;
        logic [TEX_W-1:0]      tex_v;
        logic                  last_vertex;
    } t_vtx_out;

    typedef struct packed {
        logic [2:0][POS_W-1:0] scale;
        logic [2:0][POS_W-1:0] offset;
        logic [SZ_W-1:0]       skin_w;
        logic [SZ_W-1:0]       skin_h;
    } t_xform;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic [S_USER_W-1:0]  s_tuser = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tready = 1'b0;
    wire                  o_cfg_ready;
    wire                  o_s_tready;
    wire                  o_m_tvalid;
    wire [M_DATA_W-1:0]   o_m_tdata;
    wire                  o_m_tlast;

    t_xform   xf;
    t_vtx_out predicted[$];
    bit       idle_on = 1'b1;
    int       rx_hold = 0;
    int       errors = 0;
    int       out_beats = 0;
    int       quiet_cycles = 0;

    keyframe_vertex_interpolator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    always #4 clk = ~clk;

    task automatic flag_error(input string msg);
        errors++;
        $display("ERROR: %s", msg);
    endtask

    function automatic logic [TEX_W-1:0] tex_norm(input longint unsigned h,
                                                  input logic [SZ_W-1:0] size);
        longint unsigned d;
        longint unsigned q;
        if (size == '0)
            return TEX_MAX;
        d = size;
        q = ((h << COORD_FRAC_BITS) + d) / (2 * d);
        return (q > TEX_MAX) ? TEX_MAX : q[TEX_W-1:0];
    endfunction

    function automatic t_vtx_out predict_vertex(input t_vertex v);
        t_vtx_out r;
        longint fr;
        longint p;
        longint acc;
        longint unsigned hs;
        longint unsigned ht;
        fr = (v.blend > BLEND_ONE) ? longint'(BLEND_ONE) : longint'(v.blend);
        for (int k = 0; k < 3; k++) begin
            // blended Q8.8 position, then scale with round-half-up and floor shift
            p = longint'(v.cur[k]) * 256 + fr * (longint'(v.nxt[k]) - longint'(v.cur[k]));
            acc = (longint'($signed(xf.scale[k])) * p + 128) >>> 8;
            acc += longint'($signed(xf.offset[k]));
            if (acc > POS_HI)
                acc = POS_HI;
            else if (acc < POS_LO)
                acc = POS_LO;
            r.pos[k] = acc[POS_W-1:0];
        end
        hs = 2 * longint'(v.tex_s) + 1;
        ht = 2 * longint'(v.tex_t) + 1;
        if (v.on_seam && !v.faces_front)
            hs += xf.skin_w;
        r.tex_u = tex_norm(hs, xf.skin_w);
        r.tex_v = tex_norm(ht, xf.skin_h);
        r.last_vertex = v.last_in;
        return r;
    endfunction

    function automatic t_vertex vtx(input logic [23:0] cur, input logic [23:0] nxt,
                                    input logic [BL_W-1:0] blend,
                                    input logic [TC_W-1:0] s, input logic [TC_W-1:0] t,
                                    input logic seam, input logic front, input logic last_in);
        t_vertex v;
        v.cur = cur;
        v.nxt = nxt;
        v.blend = blend;
        v.tex_s = s;
        v.tex_t = t;
        v.on_seam = seam;
        v.faces_front = front;
        v.last_in = last_in;
        return v;
    endfunction

    function automatic t_vertex random_vertex();
        t_vertex v;
        v.cur = 24'($urandom());
        v.nxt = ($urandom_range(9, 0) == 0) ? v.cur : 24'($urandom());
        case ($urandom_range(7, 0))
            0: v.blend = '0;
            1: v.blend = BLEND_ONE;
            2: v.blend = BL_W'($urandom_range(511, 257));
            default: v.blend = BL_W'($urandom_range(256, 0));
        endcase
        v.tex_s = TC_W'($urandom());
        v.tex_t = TC_W'($urandom());
        v.on_seam = 1'($urandom());
        v.faces_front = 1'($urandom());
        v.last_in = ($urandom_range(15, 0) == 0);
        return v;
    endfunction

    function automatic t_xform xform(input logic [3*POS_W-1:0] scl,
                                     input logic [3*POS_W-1:0] ofs,
                                     input logic [SZ_W-1:0] sw, input logic [SZ_W-1:0] sh);
        t_xform c;
        c.scale = scl;
        c.offset = ofs;
        c.skin_w = sw;
        c.skin_h = sh;
        return c;
    endfunction

    function automatic logic [POS_W-1:0] random_q16();
        case ($urandom_range(3, 0))
            0: return $urandom();
            1: return 32'($urandom_range(524288, 0)) - 32'h0004_0000;
            2: begin
                case ($urandom_range(3, 0))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0;
                    default: return 32'h0001_0000;
                endcase
            end
            default: return 32'($urandom_range(33554432, 0)) - 32'h0100_0000;
        endcase
    endfunction

    function automatic logic [SZ_W-1:0] random_skin();
        case ($urandom_range(15, 0))
            0: return '0;
            1: return SZ_W'($urandom_range(8191, 4097));
            2, 3: return SZ_W'(1 << $urandom_range(12, 0));
            default: return SZ_W'($urandom_range(4096, 1));
        endcase
    endfunction

    function automatic t_xform random_xform();
        t_xform c;
        for (int k = 0; k < 3; k++) begin
            c.scale[k] = random_q16();
            c.offset[k] = random_q16();
        end
        c.skin_w = random_skin();
        c.skin_h = random_skin();
        return c;
    endfunction

    task automatic send_vertex(input t_vertex v);
        int gap;
        gap = idle_on ? $urandom_range(8, 0) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({v.tex_t, v.tex_s, v.blend, v.nxt, v.cur});
        s_tuser  <= {v.faces_front, v.on_seam};
        s_tlast  <= v.last_in;
        do @(posedge clk); while (!o_s_tready);
        predicted.push_back(predict_vertex(v));
    endtask

    // sender stops and waits until the pipeline is empty
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (predicted.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!o_cfg_ready);
    endtask

    task automatic load_config(input t_xform c);
        wait_idle();
        write_reg(REG_SCALE_X, c.scale[0]);
        write_reg(REG_SCALE_Y, c.scale[1]);
        write_reg(REG_SCALE_Z, c.scale[2]);
        write_reg(REG_TRANSLATE_X, c.offset[0]);
        write_reg(REG_TRANSLATE_Y, c.offset[1]);
        write_reg(REG_TRANSLATE_Z, c.offset[2]);
        write_reg(REG_SKIN_WIDTH, 32'(c.skin_w));
        write_reg(REG_SKIN_HEIGHT, 32'(c.skin_h));
        cfg_valid <= 1'b0;
        xf = c;
    endtask

    task automatic test_reset_config();
        send_vertex(vtx(24'h000000, 24'hFFFFFF, '0, 12'd0, 12'd0, 1'b0, 1'b1, 1'b0));
        send_vertex(vtx(24'hFFFFFF, 24'h000000, '0, 12'd4095, 12'd4095, 1'b0, 1'b1, 1'b0));
        send_vertex(vtx(24'hFFFFFF, 24'h000000, BLEND_ONE, 12'd7, 12'd9, 1'b0, 1'b1, 1'b0));
        send_vertex(vtx(24'h00FF80, 24'hFF0001, 9'd128, 12'd1, 12'd2, 1'b1, 1'b0, 1'b0));
        // blend past one clamps to the next frame
        send_vertex(vtx(24'h123456, 24'hABCDEF, 9'd511, 12'd100, 12'd200, 1'b0, 1'b0, 1'b0));
        send_vertex(vtx(24'hABCDEF, 24'h123456, 9'd257, 12'd255, 12'd256, 1'b1, 1'b1, 1'b0));
        send_vertex(vtx(24'h7F807F, 24'h807F80, 9'd1, 12'd4095, 12'd0, 1'b1, 1'b0, 1'b0));
        send_vertex(vtx(24'h010203, 24'hFEFDFC, 9'd255, 12'd0, 12'd4095, 1'b1, 1'b1, 1'b0));
        send_vertex(vtx(24'h55AA55, 24'hAA55AA, 9'd64, 12'hAAA, 12'h555, 1'b0, 1'b0, 1'b0));
        send_vertex(vtx(24'h800000, 24'h0000FF, 9'd192, 12'h555, 12'hAAA, 1'b1, 1'b0, 1'b1));
    endtask

    task automatic test_config_extremes();
        t_xform corner[3];
        corner[0] = xform({3{32'h7FFF_FFFF}}, {3{32'h7FFF_FFFF}}, 13'd1, 13'd8191);
        corner[1] = xform({3{32'h8000_0000}}, {3{32'h8000_0000}}, 13'd0, 13'd0);
        corner[2] = xform({32'h0, 32'h8000_0000, 32'h7FFF_FFFF},
                          {32'h8000_0000, 32'h7FFF_FFFF, 32'h0}, 13'd4096, 13'd1);
        foreach (corner[i]) begin
            load_config(corner[i]);
            send_vertex(vtx(24'hFFFFFF, 24'hFFFFFF, BLEND_ONE, 12'd4095, 12'd4095,
                            1'b1, 1'b0, 1'b0));
            send_vertex(vtx(24'h000000, 24'h000000, '0, 12'd0, 12'd0, 1'b0, 1'b1, 1'b0));
            send_vertex(vtx(24'hFFFFFF, 24'h000000, 9'd128, 12'd2048, 12'd4095,
                            1'b0, 1'b0, 1'b1));
            send_vertex(random_vertex());
        end
    endtask

    task automatic test_random_stream();
        for (int phase = 0; phase < 5; phase++) begin
            load_config(random_xform());
            idle_on = (phase != 2);
            repeat (130) send_vertex(random_vertex());
        end
        idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        load_config(random_xform());
        // output blocked for a long stretch while input keeps streaming
        idle_on = 1'b0;
        rx_hold = 64;
        repeat (40) send_vertex(random_vertex());
        idle_on = 1'b1;
        wait_idle();
        repeat (40) send_vertex(random_vertex());
    endtask

    // output side: random ready gaps, plus a long hold on request
    initial begin
        int gap;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            gap = idle_on ? $urandom_range(8, 0) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(o_m_tvalid && m_tready));
        end
    end

    always @(posedge clk) begin
        t_vtx_out want;
        if (rst_n && o_m_tvalid && m_tready) begin
            out_beats++;
            if (predicted.size() == 0) begin
                flag_error($sformatf("beat %0d arrived with nothing outstanding", out_beats));
            end else begin
                want = predicted.pop_front();
                for (int k = 0; k < 3; k++)
                    if (o_m_tdata[k*POS_W +: POS_W] !== want.pos[k])
                        flag_error($sformatf("beat %0d pos[%0d] got %h want %h", out_beats, k,
                                             o_m_tdata[k*POS_W +: POS_W], want.pos[k]));
                if (o_m_tdata[3*POS_W +: TEX_W] !== want.tex_u)
                    flag_error($sformatf("beat %0d tex_u got %h want %h", out_beats,
                                         o_m_tdata[3*POS_W +: TEX_W], want.tex_u));
                if (o_m_tdata[3*POS_W+TEX_W +: TEX_W] !== want.tex_v)
                    flag_error($sformatf("beat %0d tex_v got %h want %h", out_beats,
                                         o_m_tdata[3*POS_W+TEX_W +: TEX_W], want.tex_v));
                if (o_m_tlast !== want.last_vertex)
                    flag_error($sformatf("beat %0d tlast got %b want %b", out_beats,
                                         o_m_tlast, want.last_vertex));
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready) || (cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        xf = xform({3{32'h0001_0000}}, '0, 13'd256, 13'd256);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_config();
        test_config_extremes();
        test_random_stream();
        test_backpressure();
        wait_idle();
        if (predicted.size() != 0)
            flag_error($sformatf("%0d results never arrived", predicted.size()));
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/kvi_pkg.sv
src/keyframe_vertex_interpolator.sv
src/kvi_checker.sv
sim/tb_keyframe_vertex_interpolator.sv
